>>> sv/idi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idi_pkg
// Shared types and constants of the inverse-distance interpolator.
// ----------------------------------------------------------------------------
package idi_pkg;

	localparam int MAX_POINTS_DEF = 256;

	// accumulator and divider widths, sized for the largest point store (4096)
	localparam int NUM_W  = 77;   // signed sum of w*z
	localparam int DEN_W  = 61;   // sum of weights
	localparam int DVD_W  = 77;   // dividend shift register
	localparam int DVS_W  = 62;   // divisor
	localparam int QUO_W  = 49;   // quotient kept (weight fits here)
	localparam int CNT_W  = 7;    // divider step counter
	localparam int WGT_STEPS = 49; // 2^48 / d^4 needs 49 quotient bits

	localparam logic [11:0] RADIUS_RESET = 12'd4095;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_QUERY  = 2'd2
	} req_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_APPEND,
		OP_QSTART,
		OP_READ,
		OP_DIFF,
		OP_SQ,
		OP_SUM,
		OP_SKIP,
		OP_WSQ,
		OP_WLOAD,
		OP_DSTEP,
		OP_MLO,
		OP_MHI,
		OP_ACC,
		OP_FMAG,
		OP_FLOAD,
		OP_OUT_HIT,
		OP_OUT_NONE,
		OP_OUT_VAL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} idi_cmd_t;

	typedef struct packed {
		logic at_end;
		logic hit;
		logic in_range;
		logic div_done;
		logic no_contrib;
		logic out_free;
	} idi_stat_t;

endpackage
`default_nettype wire

>>> sv/inverse_distance_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_distance_interpolator_core
// Inverse-distance (power 4) interpolation over a store of scattered points.
// ----------------------------------------------------------------------------
// Clear and append beats are taken in idle. A query walks the stored points in
// append order, one at a time through a single-port store: a point outside the
// radius is skipped after its distance check, a point inside also gets its
// weight 2^48/d^4 from the shared bit-serial divider (49 steps). The final
// rounded average uses the same divider for 77 more steps before the result
// is loaded. An exact hit ends the walk at once.
// Only one request is in progress at a time; a finished result waits in the
// output register while the next beat is taken.
module inverse_distance_interpolator_core #(
	parameter int MAX_POINTS = idi_pkg::MAX_POINTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // pos_x, pos_y, sample_z
	input  wire logic [1:0]  s_tuser,   // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // interp_value, exact_hit, used_points,
	                                    // none_in_range, zero pad
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata  // search_radius
);
	import idi_pkg::*;

	idi_cmd_t  cmd;
	idi_stat_t stat;

	idi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	idi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tready  (m_tready),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

	// a hit result reports exactly one used point
	a_hit_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[25:17] == 9'd1)
		else $error("exact hit with wrong point count");

	// an empty result carries value zero and no hit
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[26] |-> m_tdata[15:0] == 16'd0 && !m_tdata[16])
		else $error("empty result not zero");

	// a result is only loaded while no request is being taken
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT_VAL || cmd.op == OP_OUT_HIT || cmd.op == OP_OUT_NONE)
		|-> !s_tready)
		else $error("result loaded while idle");

endmodule
`default_nettype wire

>>> sv/idi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idi_ctrl
// Request sequencer: walks the point store and steps the shared divider.
// ----------------------------------------------------------------------------
module idi_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic [1:0]        req_type,
	input  wire idi_pkg::idi_stat_t stat,
	output logic                   s_tready,
	output idi_pkg::idi_cmd_t      cmd
);
	import idi_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD, ST_DIFF, ST_SQ, ST_SUM, ST_CHK, ST_WSQ, ST_WLOAD, ST_WDIV,
		ST_MLO, ST_MHI, ST_ACC, ST_FIN, ST_FMAG, ST_FLOAD, ST_FDIV, ST_FOUT, ST_HIT
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (req_type)
						REQ_CLEAR:  cmd.op = OP_CLEAR;
						REQ_APPEND: cmd.op = OP_APPEND;
						REQ_QUERY: begin
							cmd.op  = OP_QSTART;
							state_d = ST_RD;
						end
						default: cmd.op = OP_NONE;
					endcase
				end
			end
			ST_RD: begin
				if (stat.at_end) begin
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_READ;
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op  = OP_SQ;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				priority if (stat.hit) begin
					state_d = ST_HIT;
				end else if (!stat.in_range) begin
					cmd.op  = OP_SKIP;
					state_d = ST_RD;
				end else begin
					cmd.op  = OP_WSQ;
					state_d = ST_WLOAD;
				end
			end
			ST_WSQ: state_d = ST_WLOAD;
			ST_WLOAD: begin
				cmd.op  = OP_WLOAD;
				state_d = ST_WDIV;
			end
			ST_WDIV: begin
				if (stat.div_done) state_d = ST_MLO;
				else cmd.op = OP_DSTEP;
			end
			ST_MLO: begin
				cmd.op  = OP_MLO;
				state_d = ST_MHI;
			end
			ST_MHI: begin
				cmd.op  = OP_MHI;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_RD;
			end
			ST_FIN: begin
				if (!stat.no_contrib) begin
					state_d = ST_FMAG;
				end else if (stat.out_free) begin
					cmd.op  = OP_OUT_NONE;
					state_d = ST_IDLE;
				end
			end
			ST_FMAG: begin
				cmd.op  = OP_FMAG;
				state_d = ST_FLOAD;
			end
			ST_FLOAD: begin
				cmd.op  = OP_FLOAD;
				state_d = ST_FDIV;
			end
			ST_FDIV: begin
				if (stat.div_done) state_d = ST_FOUT;
				else cmd.op = OP_DSTEP;
			end
			ST_FOUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT_VAL;
					state_d = ST_IDLE;
				end
			end
			ST_HIT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT_HIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state and the ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			s_tready <= 1'b1;
		end else begin
			state_q  <= state_d;
			s_tready <= (state_d == ST_IDLE);
		end
	end

endmodule
`default_nettype wire

>>> sv/idi_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idi_dp
// Point store, distance and weight arithmetic, accumulators, shared divider
// and output register.
// ----------------------------------------------------------------------------
module idi_dp #(
	parameter int MAX_POINTS = idi_pkg::MAX_POINTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire idi_pkg::idi_cmd_t cmd,
	input  wire logic [47:0]       s_tdata,
	input  wire logic              cfg_we,
	input  wire logic [11:0]       cfg_wdata,
	input  wire logic              m_tready,
	output idi_pkg::idi_stat_t     stat,
	output logic                   m_tvalid,
	output logic [31:0]            m_tdata
);
	import idi_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

	logic [47:0]       mem [MAX_POINTS];
	logic [47:0]       rd_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [11:0]       radius_q;
	logic [23:0]       r2_q;
	logic [15:0]       qx_q, qy_q;
	logic [15:0]       dx_s1, dy_s1;
	logic [15:0]       z_s1;
	logic [31:0]       sqx_s2, sqy_s2;
	logic [32:0]       d2_s3;
	logic [47:0]       d2sq_q;
	logic [DVD_W-1:0]  ddnd_q;
	logic [DVS_W-1:0]  dvsr_q;
	logic [DVS_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [47:0]       plo_q;
	logic [32:0]       phi_q;
	logic signed [NUM_W-1:0] num_q;
	logic [DEN_W-1:0]  den_q;
	logic [8:0]        used_q;
	logic              any_q;
	logic              neg_q;
	logic [NUM_W-2:0]  mag_q;

	logic signed [16:0] ddx, ddy;
	logic [15:0]        zmag;
	logic [DVS_W:0]     trial;
	logic               ge;
	logic [64:0]        prod;
	logic [15:0]        qval;

	// signed coordinate differences between the query and the point just read
	always_comb begin
		ddx = $signed({qx_q[15], qx_q}) - $signed({rd_q[15], rd_q[15:0]});
		ddy = $signed({qy_q[15], qy_q}) - $signed({rd_q[31], rd_q[31:16]});
	end

	assign zmag  = z_s1[15] ? 16'(-z_s1) : z_s1;
	assign trial = {rem_q, ddnd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvsr_q};
	assign prod  = {phi_q, 32'b0} + {17'b0, plo_q};
	assign qval  = neg_q ? 16'(-quo_q[15:0]) : quo_q[15:0];

	// status back to the sequencer
	always_comb begin
		stat.at_end     = (k_q == count_q);
		stat.hit        = (d2_s3 == 33'd0);
		stat.in_range   = (d2_s3 <= {9'b0, r2_q});
		stat.div_done   = (cnt_q == '0);
		stat.no_contrib = !any_q || (den_q == '0);
		stat.out_free   = !m_tvalid || m_tready;
	end

	// point store
	always_ff @(posedge clk) begin
		if (cmd.op == OP_APPEND && count_q != MAX_CNT) begin
			mem[count_q[AW-1:0]] <= s_tdata;
		end
		if (cmd.op == OP_READ) begin
			rd_q <= mem[k_q[AW-1:0]];
		end
	end

	// control state: fill count, radius, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			radius_q <= RADIUS_RESET;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) radius_q <= cfg_wdata;
			if (cmd.op == OP_CLEAR) begin
				count_q <= '0;
			end else if (cmd.op == OP_APPEND && count_q != MAX_CNT) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.op == OP_OUT_HIT || cmd.op == OP_OUT_NONE || cmd.op == OP_OUT_VAL) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		r2_q <= radius_q * radius_q;
		unique case (cmd.op)
			OP_QSTART: begin
				qx_q   <= s_tdata[15:0];
				qy_q   <= s_tdata[31:16];
				k_q    <= '0;
				num_q  <= '0;
				den_q  <= '0;
				used_q <= '0;
				any_q  <= 1'b0;
			end
			OP_DIFF: begin
				dx_s1 <= ddx[16] ? 16'(-ddx) : ddx[15:0];
				dy_s1 <= ddy[16] ? 16'(-ddy) : ddy[15:0];
				z_s1  <= rd_q[47:32];
			end
			OP_SQ: begin
				sqx_s2 <= dx_s1 * dx_s1;
				sqy_s2 <= dy_s1 * dy_s1;
			end
			OP_SUM:  d2_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			OP_SKIP: k_q    <= k_q + 1'b1;
			OP_WSQ:  d2sq_q <= d2_s3[23:0] * d2_s3[23:0];
			OP_WLOAD: begin
				ddnd_q <= {1'b1, {(DVD_W-1){1'b0}}};
				dvsr_q <= DVS_W'(d2sq_q);
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= CNT_W'(WGT_STEPS);
			end
			OP_DSTEP: begin
				rem_q  <= ge ? DVS_W'(trial - {1'b0, dvsr_q}) : DVS_W'(trial);
				ddnd_q <= {ddnd_q[DVD_W-2:0], 1'b0};
				quo_q  <= {quo_q[QUO_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			OP_MLO: plo_q <= quo_q[31:0] * zmag;
			OP_MHI: phi_q <= quo_q[48:32] * zmag;
			OP_ACC: begin
				num_q  <= z_s1[15] ? num_q - $signed(NUM_W'(prod))
				                   : num_q + $signed(NUM_W'(prod));
				den_q  <= den_q + DEN_W'(quo_q);
				used_q <= used_q + 1'b1;
				any_q  <= 1'b1;
				k_q    <= k_q + 1'b1;
			end
			OP_FMAG: begin
				neg_q <= num_q[NUM_W-1];
				mag_q <= num_q[NUM_W-1] ? (NUM_W-1)'(-num_q) : num_q[NUM_W-2:0];
			end
			OP_FLOAD: begin
				ddnd_q <= DVD_W'({mag_q, 1'b0}) + DVD_W'(den_q);
				dvsr_q <= DVS_W'({den_q, 1'b0});
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= CNT_W'(DVD_W);
			end
			OP_OUT_HIT:  m_tdata <= {5'b0, 1'b0, 9'd1, 1'b1, z_s1};
			OP_OUT_NONE: m_tdata <= {5'b0, 1'b1, 9'd0, 1'b0, 16'd0};
			OP_OUT_VAL:  m_tdata <= {5'b0, 1'b0, used_q, 1'b0, qval};
			default: ;
		endcase
	end

endmodule
`default_nettype wire
